[hdl/mpq_pkg.sv]
package mpq_pkg;

	localparam int Capacity = 64;
	localparam int AddrW = $clog2(Capacity);
	localparam int CountW = $clog2(Capacity + 1);
	localparam int EntryW = 96;

	typedef enum logic [1:0] {
		MODE_INSERT  = 2'd0,
		MODE_EXTRACT = 2'd1,
		MODE_PEEK    = 2'd2,
		MODE_SETPRI  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] element;
		logic signed [31:0] priority_req;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_element;
		logic signed [31:0] out_priority;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_MOVE,
		S_OUT
	} state_t;

endpackage

[hdl/mpq_ram.sv]
module mpq_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/min_priority_queue_top.sv]
// Insert, and any operation on an empty queue, presents its result in the cycle after the transfer.
// Peek and set-priority scan all entries; extract also moves the last entry into the freed slot.
// Throughput: one item at a time; the next item is taken the cycle after the result transfer.
// The scan reads one entry per cycle through the single read port of the entry RAM.
// Reset clears the entry count, insert serial and control; entry RAM holds no reset.
module min_priority_queue_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mpq_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mpq_pkg::out_item_t  out_data
);
	import mpq_pkg::*;

	state_t state_q, state_d;
	in_item_t req_q;
	logic [CountW-1:0] count_q;
	logic [31:0] serial_q;
	logic [CountW-1:0] idx_q;
	logic [AddrW-1:0] best_q;
	logic [95:0] best_ent_q;
	logic have_q;
	out_item_t res_q;
	logic res_valid_q;

	logic we;
	logic [AddrW-1:0] waddr, raddr;
	logic [95:0] wdata, rdata;
	logic rd_valid_q;
	logic [AddrW-1:0] rd_addr_q;

	mpq_ram #(.Width(EntryW), .Depth(Capacity)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic accept;
	assign in_stall = (state_q != S_IDLE) || res_valid_q;
	assign accept = in_valid && !in_stall;
	assign out_valid = res_valid_q;
	assign out_data = res_q;

	logic [31:0] r_el, r_pr, r_age, b_pr, b_age;
	assign r_el = rdata[95:64];
	assign r_pr = rdata[63:32];
	assign r_age = rdata[31:0];
	assign b_pr = best_ent_q[63:32];
	assign b_age = best_ent_q[31:0];

	logic better;
	always_comb begin
		if ((r_pr ^ 32'h8000_0000) != (b_pr ^ 32'h8000_0000)) begin
			better = (r_pr ^ 32'h8000_0000) < (b_pr ^ 32'h8000_0000);
		end else begin
			better = (serial_q - r_age) > (serial_q - b_age);
		end
	end

	logic scan_end;
	assign scan_end = (idx_q == count_q);

	status_t acc_status;
	always_comb begin
		acc_status = ST_DONE;
		if (in_data.mode == MODE_INSERT) begin
			if (count_q >= CountW'(Capacity)) begin
				acc_status = ST_FULL;
			end
		end else if (count_q == '0 && in_data.mode != MODE_SETPRI) begin
			acc_status = ST_EMPTY;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && in_data.mode != MODE_INSERT && count_q != '0) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_end && !rd_valid_q) begin
					state_d = (req_q.mode == MODE_EXTRACT) ? S_LAST : S_OUT;
				end
			end
			S_LAST:  state_d = S_MOVE;
			S_MOVE:  state_d = S_OUT;
			S_OUT:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = rdata;
		raddr = idx_q[AddrW-1:0];
		case (state_q)
			S_IDLE: begin
				waddr = count_q[AddrW-1:0];
				wdata = {in_data.element, in_data.priority_req, serial_q};
				we = accept && in_data.mode == MODE_INSERT && count_q < CountW'(Capacity);
			end
			S_SCAN: begin
				waddr = rd_addr_q;
				wdata = {r_el, req_q.priority_req, r_age};
				we = rd_valid_q && req_q.mode == MODE_SETPRI && r_el == req_q.element;
			end
			S_LAST: raddr = AddrW'(count_q - CountW'(1));
			S_MOVE: begin
				waddr = best_q;
				wdata = rdata;
				we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			serial_q <= '0;
			res_valid_q <= 1'b0;
			rd_valid_q <= 1'b0;
			idx_q <= '0;
			have_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_valid_q && !out_stall) begin
				res_valid_q <= 1'b0;
			end
			rd_valid_q <= (state_q == S_SCAN) && !scan_end;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					have_q <= 1'b0;
					if (accept) begin
						req_q <= in_data;
						res_q <= '{status: acc_status, out_element: '0, out_priority: '0};
						if (in_data.mode == MODE_INSERT) begin
							res_valid_q <= 1'b1;
							if (count_q < CountW'(Capacity)) begin
								count_q <= count_q + CountW'(1);
								serial_q <= serial_q + 32'd1;
							end
						end else if (count_q == '0) begin
							res_valid_q <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (!scan_end) begin
						idx_q <= idx_q + CountW'(1);
						rd_addr_q <= idx_q[AddrW-1:0];
					end
					if (rd_valid_q && (!have_q || better)) begin
						have_q <= 1'b1;
						best_q <= rd_addr_q;
						best_ent_q <= rdata;
					end
				end
				S_LAST: ;
				S_MOVE: begin
					count_q <= count_q - CountW'(1);
				end
				S_OUT: begin
					res_valid_q <= 1'b1;
					if (req_q.mode != MODE_SETPRI) begin
						res_q.out_element <= best_ent_q[95:64];
						res_q.out_priority <= best_ent_q[63:32];
					end
				end
				default: ;
			endcase
		end
	end
endmodule
